// ----- rtl/core/iisb_pkg.sv -----
// ----------------------------------------------------------------------------
// iisb_pkg: shared types and constants of the indexed insert shift buffer
// Holds the operation and status codes, field widths, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package iisb_pkg;

  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic [FuncW-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_INSERT     = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_READ       = 3'd4,
    FN_WRITE      = 3'd5,
    FN_SORT       = 3'd6
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic  exec;      // execute op this cycle (transaction accepted)
    func_e op;
    logic  sort_en;   // run one compare-exchange pass
    logic  sort_odd;  // pass pairs start at odd cells
  } dp_cmd_t;

  // Datapath to controller: outcome of the op presented this cycle
  typedef struct packed {
    logic [ValueW-1:0] read_data;
    logic [CountW-1:0] count;
    status_e           status;
  } dp_sts_t;

endpackage

// ----- rtl/core/iisb_req_if.sv -----
// ----------------------------------------------------------------------------
// iisb_req_if: request channel
// Valid/ready handshake carrying one operation request.
// ----------------------------------------------------------------------------
interface iisb_req_if;
  logic                         valid;
  logic                         ready;
  logic [iisb_pkg::FuncW-1:0]   func;
  logic [iisb_pkg::PosW-1:0]    position;
  logic [iisb_pkg::ValueW-1:0]  value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

// ----- rtl/core/iisb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// iisb_rsp_if: response channel
// Valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface iisb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [iisb_pkg::ValueW-1:0]   read_data;
  logic [iisb_pkg::CountW-1:0]   count;
  logic [iisb_pkg::StatusW-1:0]  status;

  modport source (output valid, read_data, count, status, input ready);
  modport sink   (input valid, read_data, count, status, output ready);
endinterface

// ----- rtl/core/iisb_dp.sv -----
// ----------------------------------------------------------------------------
// iisb_dp: entry array and fill count
// Row of entry cells with neighbor shifting, indexed read/write, and one
// odd-even compare-exchange pass per sort step.
// ----------------------------------------------------------------------------
module iisb_dp #(
  parameter int unsigned DEPTH      = iisb_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = iisb_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iisb_pkg::dp_cmd_t             cmd_i,
  input  logic [iisb_pkg::PosW-1:0]     position_i,
  input  logic [iisb_pkg::ValueW-1:0]   value_i,
  output iisb_pkg::dp_sts_t             sts_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned PW = (CW > iisb_pkg::PosW) ? CW : iisb_pkg::PosW;

  logic [DATA_WIDTH-1:0] ent_q [DEPTH];
  logic [DATA_WIDTH-1:0] ent_d [DEPTH];
  logic [CW-1:0]         fill_q, fill_d;

  logic [PW-1:0]         fill_w, pos_w, cnt_w;
  logic [IW-1:0]         idx;
  logic [63:0]           val_w, rd_w;
  logic [DATA_WIDTH-1:0] val_s;
  logic                  full, wr_en;
  iisb_pkg::status_e     status;

  assign fill_w = PW'(fill_q);
  assign pos_w  = PW'(position_i);
  assign idx    = pos_w[IW-1:0];
  assign val_w  = 64'(value_i);
  assign val_s  = val_w[DATA_WIDTH-1:0];
  assign full   = (fill_w >= PW'(DEPTH));

  always_comb begin
    status = iisb_pkg::ST_OK;
    fill_d = fill_q;
    rd_w   = '0;
    case (cmd_i.op)
      iisb_pkg::FN_PUSH_BACK, iisb_pkg::FN_PUSH_FRONT: begin
        if (full) status = iisb_pkg::ST_FULL;
        else      fill_d = fill_q + CW'(1);
      end
      iisb_pkg::FN_INSERT: begin
        if (full)                status = iisb_pkg::ST_FULL;
        else if (pos_w > fill_w) status = iisb_pkg::ST_RANGE;
        else                     fill_d = fill_q + CW'(1);
      end
      iisb_pkg::FN_POP_BACK: begin
        if (fill_q == '0) status = iisb_pkg::ST_EMPTY;
        else              fill_d = fill_q - CW'(1);
      end
      iisb_pkg::FN_READ: begin
        if (pos_w >= fill_w) status = iisb_pkg::ST_RANGE;
        else                 rd_w   = 64'(ent_q[idx]);
      end
      iisb_pkg::FN_WRITE: begin
        if (pos_w >= fill_w) status = iisb_pkg::ST_RANGE;
      end
      default: ;
    endcase
  end

  assign wr_en = cmd_i.exec && (status == iisb_pkg::ST_OK);
  assign cnt_w = PW'(fill_d);

  assign sts_o.read_data = rd_w[iisb_pkg::ValueW-1:0];
  assign sts_o.count     = cnt_w[iisb_pkg::CountW-1:0];
  assign sts_o.status    = status;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [PW-1:0] IDX  = PW'(g);
    localparam logic [PW-1:0] IDX1 = PW'(g + 1);
    localparam logic          PAR  = 1'(g % 2);

    logic [DATA_WIDTH-1:0] prev_w, next_w;
    logic                  has_next;

    if (g > 0) begin : g_prev
      assign prev_w = ent_q[g-1];
    end else begin : g_noprev
      assign prev_w = '0;
    end

    if (g < DEPTH - 1) begin : g_next
      assign next_w   = ent_q[g+1];
      assign has_next = 1'b1;
    end else begin : g_nonext
      assign next_w   = '0;
      assign has_next = 1'b0;
    end

    always_comb begin
      ent_d[g] = ent_q[g];
      if (cmd_i.sort_en) begin
        // lower cell of a pair keeps the min, upper cell the max
        if (PAR == cmd_i.sort_odd) begin
          if (has_next && (IDX1 < fill_w) && (ent_q[g] > next_w)) ent_d[g] = next_w;
        end else if (g > 0) begin
          if ((IDX < fill_w) && (prev_w > ent_q[g])) ent_d[g] = prev_w;
        end
      end else if (wr_en) begin
        case (cmd_i.op)
          iisb_pkg::FN_PUSH_BACK: begin
            if (IDX == fill_w) ent_d[g] = val_s;
          end
          iisb_pkg::FN_PUSH_FRONT: begin
            ent_d[g] = (g == 0) ? val_s : prev_w;
          end
          iisb_pkg::FN_INSERT: begin
            if (IDX == pos_w)     ent_d[g] = val_s;
            else if (IDX > pos_w) ent_d[g] = prev_w;
          end
          iisb_pkg::FN_WRITE: begin
            if (IDX == pos_w) ent_d[g] = val_s;
          end
          default: ;
        endcase
      end
    end

    always_ff @(posedge clk_i) begin
      ent_q[g] <= ent_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.exec) begin
      fill_q <= fill_d;
    end
  end

endmodule

// ----- rtl/core/iisb_ctrl.sv -----
// ----------------------------------------------------------------------------
// iisb_ctrl: handshake and sort sequencer
// Accepts requests, registers the result, and steps the sort passes.
// ----------------------------------------------------------------------------
module iisb_ctrl #(
  parameter int unsigned DEPTH = iisb_pkg::DepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic [iisb_pkg::FuncW-1:0]      func_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output iisb_pkg::dp_sts_t               out_o,
  output iisb_pkg::dp_cmd_t               cmd_o,
  input  iisb_pkg::dp_sts_t               sts_i
);

  localparam int unsigned PassW = $clog2(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SORT
  } state_e;

  state_e            state_q;
  logic [PassW-1:0]  pass_q;
  logic              out_valid_q;
  iisb_pkg::dp_sts_t out_q;
  logic              accept;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.exec     = accept;
  assign cmd_o.op       = iisb_pkg::func_e'(func_i);
  assign cmd_o.sort_en  = (state_q == S_SORT);
  assign cmd_o.sort_odd = pass_q[0];

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        out_q       <= sts_i;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (cmd_o.op == iisb_pkg::FN_SORT)) begin
            state_q <= S_SORT;
            pass_q  <= '0;
          end
        end
        S_SORT: begin
          pass_q <= pass_q + PassW'(1);
          if (pass_q == PassW'(DEPTH - 1)) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/indexed_insert_shift_buffer.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_shift_buffer: ordered entry buffer with insert and sort
// Up to DEPTH entries with a fill count; push back/front, insert, pop back,
// indexed read/write and an ascending unsigned sort of the filled entries.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake        payload
//   req_i    in   valid / ready    func, position, value
//   rsp_o    out  valid / ready    read_data, count, status
//
// Every op except sort completes in the cycle its transaction is accepted;
// the result lands in the output register and is visible in the next cycle.
// A new request is taken whenever no sort is running and that register is
// empty or being drained, so the buffer sustains one transaction per cycle.
// Sort reports its result at once, then runs DEPTH odd-even compare-exchange
// passes over the cell row with ready low. Reset clears the fill count and
// the handshake state only; entry contents are don't-care until written.
module indexed_insert_shift_buffer #(
  parameter int unsigned DEPTH      = iisb_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = iisb_pkg::DataWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iisb_req_if.sink  req_i,
  iisb_rsp_if.source rsp_o
);

  iisb_pkg::dp_cmd_t cmd;
  iisb_pkg::dp_sts_t sts;
  iisb_pkg::dp_sts_t out;

  // Controller: handshake, result register, sort pass sequencing
  iisb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .func_i      (req_i.func),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_o       (out),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: entry cells, fill count, status evaluation
  iisb_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .position_i (req_i.position),
    .value_i    (req_i.value),
    .sts_o      (sts)
  );

  // Drive the response payload from the result register
  assign rsp_o.read_data = out.read_data;
  assign rsp_o.count     = out.count;
  assign rsp_o.status    = out.status;

endmodule

// ----- rtl/core/iisb_chk.sv -----
// ----------------------------------------------------------------------------
// iisb_chk: port-level checks of the buffer
// Watches the response channel for handshake and result consistency.
// ----------------------------------------------------------------------------
module iisb_chk #(
  parameter int unsigned DEPTH = iisb_pkg::DepthDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [iisb_pkg::ValueW-1:0]    read_data_i,
  input logic [iisb_pkg::CountW-1:0]    count_i,
  input logic [iisb_pkg::StatusW-1:0]   status_i
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i)
      && $stable(count_i) && $stable(status_i))
    else $error("stalled result changed");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == iisb_pkg::ST_FULL) |->
      (count_i == iisb_pkg::CountW'(DEPTH)))
    else $error("full status with buffer not full");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == iisb_pkg::ST_EMPTY) |-> (count_i == '0))
    else $error("empty status with entries present");

  a_rdz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != iisb_pkg::ST_OK) |-> (read_data_i == '0))
    else $error("read data on failed operation");

endmodule

bind indexed_insert_shift_buffer iisb_chk #(
  .DEPTH (DEPTH)
) u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .read_data_i (rsp_o.read_data),
  .count_i     (rsp_o.count),
  .status_i    (rsp_o.status)
);
